/* design/lpm_pkg.sv */
// ----------------------------------------------------------------------------
// lpm_pkg
// Shared types, codes and byte helpers for the line pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

	localparam int BYTE_W          = 8;
	localparam int PAT_REG_W       = 64;
	localparam int PAT_BYTES       = 16;
	localparam int PAT_SEL_W       = 4;
	localparam int PAT_LEN_W       = 5;
	localparam int COUNT_FIELD_W   = 32;
	localparam int KIND_W          = 2;
	localparam int CFG_IDX_W       = 4;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int COUNT_WIDTH_DEF = 32;

	typedef logic [BYTE_W-1:0]        byte_t;
	typedef logic [PAT_REG_W-1:0]     pat_word_t;
	typedef logic [PAT_LEN_W-1:0]     pat_len_t;
	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic [COUNT_FIELD_W-1:0] count_field_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	localparam byte_t NEWLINE_BYTE = 8'd10;

	// input commands
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// result kinds
	localparam kind_t KIND_LINE  = 2'd0;
	localparam kind_t KIND_LIST  = 2'd1;
	localparam kind_t KIND_COUNT = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_PAT_LOW  = 4'd0;
	localparam cfg_idx_t REG_PAT_HIGH = 4'd1;
	localparam cfg_idx_t REG_PAT_LEN  = 4'd2;
	localparam cfg_idx_t REG_IGN_CASE = 4'd3;
	localparam cfg_idx_t REG_WHOLE    = 4'd4;
	localparam cfg_idx_t REG_COUNT    = 4'd5;
	localparam cfg_idx_t REG_NUMBER   = 4'd6;
	localparam cfg_idx_t REG_LIST     = 4'd7;

	function automatic byte_t fold_byte(input byte_t b, input logic en);
		byte_t r;
		r = b;
		if (en && (b inside {[8'h61:8'h7a]}))
			r = b - 8'd32;
		return r;
	endfunction

	function automatic logic is_alnum(input byte_t b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

endpackage

`default_nettype wire

/* design/lpm_in_if.sv */
// ----------------------------------------------------------------------------
// lpm_in_if
// Text byte channel: command and data byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpm_in_if import lpm_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  cmd;
	byte_t data_byte;

	modport source (output valid, cmd, data_byte, input ready);
	modport sink   (input valid, cmd, data_byte, output ready);
endinterface

`default_nettype wire

/* design/lpm_out_if.sv */
// ----------------------------------------------------------------------------
// lpm_out_if
// Result channel: kind, line number and match count with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpm_out_if import lpm_pkg::*; ();
	logic         valid;
	logic         ready;
	kind_t        kind;
	count_field_t line_number;
	count_field_t match_count;

	modport source (output valid, kind, line_number, match_count, input ready);
	modport sink   (input valid, kind, line_number, match_count, output ready);
endinterface

`default_nettype wire

/* design/lpm_cfg_if.sv */
// ----------------------------------------------------------------------------
// lpm_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpm_cfg_if import lpm_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	pat_word_t data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/lpm_cell.sv */
// ----------------------------------------------------------------------------
// lpm_cell
// One window cell: holds a text byte, passes it on, compares against pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_cell import lpm_pkg::*; (
	input  wire   clk,
	input  wire   shift_en,
	input  byte_t byte_in,
	input  byte_t pat_byte,
	input  wire   fold_en,
	output byte_t byte_q,
	output logic  eq_held,
	output logic  eq_in,
	output logic  alnum_held
);

	byte_t pat_f;

	always_ff @(posedge clk) begin
		if (shift_en)
			byte_q <= byte_in;
	end

	// eq_in looks at the byte about to enter, eq_held at the stored one
	assign pat_f      = fold_byte(pat_byte, fold_en);
	assign eq_held    = (fold_byte(byte_q, fold_en) == pat_f);
	assign eq_in      = (fold_byte(byte_in, fold_en) == pat_f);
	assign alnum_held = is_alnum(byte_q);

endmodule

`default_nettype wire

/* design/line_pattern_matcher_top.sv */
// ----------------------------------------------------------------------------
// line_pattern_matcher_top
// Per-line substring search over a byte stream with a row of window cells.
// ----------------------------------------------------------------------------
// Throughput: one byte transaction per cycle unless a result is stalled; the
//   window shift and all cell compares finish in the accepting cycle.
// Latency: a result is valid the cycle after the newline or end-of-input
//   transaction that causes it, held in the output register until taken.
// Reset: arst_n clears line state, match total, stop flag and output valid;
//   line number is set to 1; registers return to pattern length 1, others 0.
// ----------------------------------------------------------------------------
`default_nettype none

module line_pattern_matcher_top import lpm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input wire          clk,
	input wire          arst_n,
	lpm_cfg_if.sink     cfg,
	lpm_in_if.sink      text,
	lpm_out_if.source   result
);

	// bytes_in_line saturates at MAX_PATTERN+1
	localparam int BIL_W = $clog2(MAX_PATTERN + 2);
	localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN + 1) : 1;
	localparam logic [BIL_W-1:0] BIL_MAX = BIL_W'(MAX_PATTERN + 1);
	localparam pat_len_t LEN_MAX = PAT_LEN_W'(MAX_PATTERN);
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

	// ---------------- configuration registers ----------------
	pat_word_t pat_lo_q, pat_hi_q;
	pat_len_t  pat_len_q;
	logic      ign_case_q, whole_q, count_q, number_q, list_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q   <= '0;
			pat_hi_q   <= '0;
			pat_len_q  <= PAT_LEN_W'(1);
			ign_case_q <= 1'b0;
			whole_q    <= 1'b0;
			count_q    <= 1'b0;
			number_q   <= 1'b0;
			list_q     <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PAT_LOW:  pat_lo_q   <= cfg.data;
				REG_PAT_HIGH: pat_hi_q   <= cfg.data;
				REG_PAT_LEN:  pat_len_q  <= cfg.data[PAT_LEN_W-1:0];
				REG_IGN_CASE: ign_case_q <= cfg.data[0];
				REG_WHOLE:    whole_q    <= cfg.data[0];
				REG_COUNT:    count_q    <= cfg.data[0];
				REG_NUMBER:   number_q   <= cfg.data[0];
				REG_LIST:     list_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// effective pattern length: 0 acts as 1, clamp to MAX_PATTERN
	pat_len_t len_e;
	always_comb begin
		if (pat_len_q == '0)
			len_e = PAT_LEN_W'(1);
		else if (pat_len_q > LEN_MAX)
			len_e = LEN_MAX;
		else
			len_e = pat_len_q;
	end

	logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
	assign pat_bytes = {pat_hi_q, pat_lo_q};

	// ---------------- stream state ----------------
	logic [BIL_W-1:0]       bil_q, bil_d, bil_inc;
	logic                   hit_q, hit_d;
	logic [COUNT_WIDTH-1:0] line_q, line_d, line_inc;
	logic [COUNT_WIDTH-1:0] total_q, total_d, total_inc;
	logic                   stopped_q, stopped_d;

	logic in_acc;
	logic shift_en;
	logic out_valid_q;

	// skid: a new byte goes in whenever the output register is free or drains
	assign text.ready = !out_valid_q || result.ready;
	assign in_acc     = text.valid && text.ready;

	// ---------------- window cell row ----------------
	// Cell 0 holds the newest byte; each cell hands its byte to the next one.
	// Cell j compares against pattern byte len-1-j, so the row lines up with
	// the pattern right-aligned on the newest byte.
	byte_t                  win [MAX_PATTERN+1];
	logic [MAX_PATTERN:0]   eq_held, eq_in, alnum_held;

	for (genvar j = 0; j <= MAX_PATTERN; j++) begin : g_cell
		pat_len_t pidx;
		byte_t    feed;

		assign pidx = len_e - PAT_LEN_W'(1) - PAT_LEN_W'(j);

		if (j == 0) begin : g_head
			assign feed = text.data_byte;
		end else begin : g_link
			assign feed = win[j-1];
		end

		lpm_cell u_cell (
			.clk        (clk),
			.shift_en   (shift_en),
			.byte_in    (feed),
			.pat_byte   (pat_bytes[pidx[PAT_SEL_W-1:0]]),
			.fold_en    (ign_case_q),
			.byte_q     (win[j]),
			.eq_held    (eq_held[j]),
			.eq_in      (eq_in[j]),
			.alnum_held (alnum_held[j])
		);
	end

	// whole-word mode checks the window before the shift, plain mode after it
	logic     tail_ok;
	pat_len_t bil_w, bil_inc_w;
	logic     plain_hit, word_cand;

	always_comb begin
		tail_ok = 1'b1;
		for (int j = 0; j <= MAX_PATTERN; j++) begin
			if (PAT_LEN_W'(j) < len_e)
				tail_ok = tail_ok && (whole_q ? eq_held[j] : eq_in[j]);
		end
	end

	assign bil_inc   = (bil_q == BIL_MAX) ? bil_q : bil_q + BIL_W'(1);
	assign bil_w     = PAT_LEN_W'(bil_q);
	assign bil_inc_w = PAT_LEN_W'(bil_inc);
	assign plain_hit = (bil_inc_w >= len_e) && tail_ok;
	// left boundary: line start or a non-alnum byte just before the match
	assign word_cand = (bil_w >= len_e) && tail_ok &&
		((bil_w == len_e) || !alnum_held[len_e[IDX_W-1:0]]);

	assign line_inc  = (line_q == CNT_MAX) ? line_q : line_q + CNT_ONE;
	assign total_inc = (total_q == CNT_MAX) ? total_q : total_q + CNT_ONE;

	// ---------------- next state and result ----------------
	logic                   res_fire;
	kind_t                  res_kind;
	logic [COUNT_WIDTH-1:0] res_line, res_count;

	always_comb begin
		bil_d     = bil_q;
		hit_d     = hit_q;
		line_d    = line_q;
		total_d   = total_q;
		stopped_d = stopped_q;
		shift_en  = 1'b0;
		res_fire  = 1'b0;
		res_kind  = KIND_LINE;
		res_line  = line_q;
		res_count = total_q;

		if (in_acc) begin
			if (text.cmd == CMD_END) begin
				if (count_q && !stopped_q) begin
					res_fire = 1'b1;
					res_kind = KIND_COUNT;
					res_line = '0;
				end
				bil_d     = '0;
				hit_d     = 1'b0;
				line_d    = CNT_ONE;
				total_d   = '0;
				stopped_d = 1'b0;
			end else if (!stopped_q) begin
				if (text.data_byte != NEWLINE_BYTE) begin
					shift_en = 1'b1;
					bil_d    = bil_inc;
					if (whole_q) begin
						if (!is_alnum(text.data_byte) && word_cand)
							hit_d = 1'b1;
					end else if (plain_hit) begin
						hit_d = 1'b1;
					end
				end else begin
					// line end: the newline itself is a right boundary
					if (hit_q || (whole_q && word_cand)) begin
						total_d   = total_inc;
						res_count = total_inc;
						if (list_q) begin
							res_fire  = 1'b1;
							res_kind  = KIND_LIST;
							stopped_d = 1'b1;
						end else if (number_q || !count_q) begin
							res_fire = 1'b1;
							res_kind = KIND_LINE;
						end
					end
					line_d = line_inc;
					bil_d  = '0;
					hit_d  = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bil_q     <= '0;
			hit_q     <= 1'b0;
			line_q    <= CNT_ONE;
			total_q   <= '0;
			stopped_q <= 1'b0;
		end else begin
			bil_q     <= bil_d;
			hit_q     <= hit_d;
			line_q    <= line_d;
			total_q   <= total_d;
			stopped_q <= stopped_d;
		end
	end

	// ---------------- output register ----------------
	kind_t        kind_q;
	count_field_t line_num_q, match_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_fire)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			kind_q      <= res_kind;
			line_num_q  <= COUNT_FIELD_W'(res_line);
			match_cnt_q <= COUNT_FIELD_W'(res_count);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.kind        = kind_q;
	assign result.line_number = line_num_q;
	assign result.match_count = match_cnt_q;

	// ---------------- assertions ----------------
`ifndef SYNTH
	a_bil_range: assert property (@(posedge clk) disable iff (!arst_n)
		bil_q <= BIL_MAX)
		else $error("line byte count beyond window depth");

	a_total_le_line: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= line_q)
		else $error("match total exceeds line number");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && text.cmd == CMD_END) |=>
		(bil_q == '0 && total_q == '0 && line_q == CNT_ONE && !stopped_q))
		else $error("end of input did not clear stream state");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !text.ready)
		else $error("byte taken while result stalled");
`endif

endmodule

`default_nettype wire
